// ----- rtl/core/mcsf_pkg.sv -----
// shared types and constants for the multi-circle smooth field block
// no dependencies; used by the top level and the testbench

package mcsf_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_COUNT    = 3'd0;
  localparam logic [2:0] REG_DIM      = 3'd1;
  localparam logic [2:0] REG_PROFILE  = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_BG_EN    = 3'd4;
  localparam logic [2:0] REG_BG_LEVEL = 3'd5;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // profile codes
  localparam logic [1:0] PROF_COS  = 2'd0;
  localparam logic [1:0] PROF_TANH = 2'd1;

  localparam logic [30:0] ONE30    = 31'h4000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [28:0] EINV_Q30 = 29'd395007542;
  localparam logic [16:0] S_ONE    = 17'd65536;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] radius;
    logic [31:0] vin;
    logic [31:0] vout;
  } circle_t;

  // taylor divisors of the cosine series, highest term first
  function automatic logic [31:0] cos_div(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'd132;
      4'd1:    r = 32'd90;
      4'd2:    r = 32'd56;
      4'd3:    r = 32'd30;
      default: r = 32'd12;
    endcase
    return r;
  endfunction

  // exact floor of a 32-bit value over a small constant:
  // q = (x * recip_mul(dv)) >> recip_shift(dv)
  function automatic logic [32:0] recip_mul(input logic [7:0] dv);
    logic [32:0] r;
    case (dv) inside
      8'd2, 8'd4, 8'd8:  r = 33'h1_0000_0000;
      8'd3, 8'd6, 8'd12: r = 33'd5726623062;
      8'd5, 8'd10:       r = 33'd6871947674;
      8'd7, 8'd56:       r = 33'd4908534053;
      8'd9:              r = 33'd7635497416;
      8'd30:             r = 33'd4581298450;
      8'd90:             r = 33'd6108397933;
      8'd132:            r = 33'd8329633544;
      default:           r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] recip_shift(input logic [7:0] dv);
    logic [5:0] r;
    case (dv) inside
      8'd2:                r = 6'd33;
      8'd3, 8'd4:          r = 6'd34;
      [8'd5:8'd8]:         r = 6'd35;
      8'd9, 8'd10, 8'd12:  r = 6'd36;
      8'd30:               r = 6'd37;
      8'd56:               r = 6'd38;
      8'd90:               r = 6'd39;
      8'd132:              r = 6'd40;
      default:             r = 6'd32;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/mcsf_div.sv -----
// restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor
// depends on nothing; used by multi_circle_smooth_field

module mcsf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        running;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [63:0] quo;
  logic [32:0] shifted;
  logic        fits;

  assign shifted  = {rem, quo[63]};
  assign fits     = shifted >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      rem <= fits ? 32'(shifted - {1'b0, dsr}) : shifted[31:0];
      quo <= {quo[62:0], fits};
    end
  end

endmodule

// ----- rtl/core/mcsf_root.sv -----
// integer square root, one root bit per cycle, 68-bit operand, 34-bit root
// depends on nothing; used by multi_circle_smooth_field

module mcsf_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [67:0] operand,
  output logic        done,
  output logic [33:0] root
);

  logic        running;
  logic [5:0]  cnt;
  logic [67:0] val;
  logic [35:0] rem;
  logic [37:0] rem_sh;
  logic [37:0] trial;
  logic        fits;

  assign rem_sh = {rem, val[67:66]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd33) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= operand;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      val  <= {val[65:0], 2'b00};
      rem  <= fits ? 36'(rem_sh - trial) : rem_sh[35:0];
      root <= {root[32:0], fits};
    end
  end

endmodule

// ----- rtl/core/multi_circle_smooth_field.sv -----
// A load item (operation 0) writes one circle entry and gives no result.
// An evaluate item (operation 1) walks the loaded circles one after another through one
// multiplier, a bit-serial square root and a bit-serial divider; busy stays high until
// the one-cycle done strobe with field_value. Per circle it computes the distance and root,
// then the profile: sharp step none, cosine inside the band one division and five series
// steps, outside it none, tanh one division when |d| is at least eight widths, else two
// divisions, ten series steps and up to fifteen exp steps. Series terms divide by small
// constants through the multiplier.
// An output state ends the item. done cannot be held off: take field_value in the cycle done
// is high.
// Depends on mcsf_pkg, mcsf_div and mcsf_root.

module multi_circle_smooth_field #(
  parameter int MAX_CIRCLES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [3:0]         circle_slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [30:0]        circle_radius,
  input  logic signed [31:0] value_inside,
  input  logic signed [31:0] value_outside,
  output logic               done,
  output logic signed [31:0] field_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_READ  = 5'd1;
  localparam logic [4:0] S_DIFF  = 5'd2;
  localparam logic [4:0] S_SQX   = 5'd3;
  localparam logic [4:0] S_SQY   = 5'd4;
  localparam logic [4:0] S_SQZ   = 5'd5;
  localparam logic [4:0] S_SUM   = 5'd6;
  localparam logic [4:0] S_ROOT  = 5'd7;
  localparam logic [4:0] S_PROF  = 5'd8;
  localparam logic [4:0] S_CDIVW = 5'd9;
  localparam logic [4:0] S_CA    = 5'd10;
  localparam logic [4:0] S_CX2   = 5'd11;
  localparam logic [4:0] S_CX2W  = 5'd12;
  localparam logic [4:0] S_CPM   = 5'd13;
  localparam logic [4:0] S_CPD   = 5'd14;
  localparam logic [4:0] S_CPW   = 5'd15;
  localparam logic [4:0] S_CFIN  = 5'd16;
  localparam logic [4:0] S_CC    = 5'd17;
  localparam logic [4:0] S_TDIVW = 5'd18;
  localparam logic [4:0] S_TPM   = 5'd19;
  localparam logic [4:0] S_TPD   = 5'd20;
  localparam logic [4:0] S_TPW   = 5'd21;
  localparam logic [4:0] S_TE    = 5'd22;
  localparam logic [4:0] S_TEW   = 5'd23;
  localparam logic [4:0] S_TRW   = 5'd24;
  localparam logic [4:0] S_TS    = 5'd25;
  localparam logic [4:0] S_VAL1  = 5'd26;
  localparam logic [4:0] S_VAL2  = 5'd27;
  localparam logic [4:0] S_VAL3  = 5'd28;
  localparam logic [4:0] S_OUT   = 5'd29;

  // configuration
  logic [4:0]  circle_count;
  logic [1:0]  dimension;
  logic [1:0]  profile_mode;
  logic [30:0] interface_width;
  logic        background_enable;
  logic [31:0] background_level;

  logic [4:0]  state;
  logic [CNT_W-1:0] circ_idx;
  logic [CNT_W-1:0] count_eff;
  logic        last;
  logic [30:0] w;
  logic        three;
  logic        sharp;

  mcsf_pkg::circle_t mem [MAX_CIRCLES];
  mcsf_pkg::circle_t rd;

  logic signed [31:0] px, py, pz;
  logic [32:0] dx, dy, dz;
  logic [67:0] acc;
  logic signed [34:0] d;
  logic [34:0] mag;
  logic [16:0] xi;
  logic [15:0] h;
  logic [31:0] x2;
  logic [30:0] p;
  logic [29:0] f30;
  logic [3:0]  n;
  logic [3:0]  k;
  logic [30:0] s30;
  logic [16:0] s;
  logic [49:0] prod;
  logic [34:0] best_abs;
  logic [31:0] best_val;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_q;

  logic        div_start, div_done;
  logic [63:0] div_dividend, div_quotient;
  logic [31:0] div_divisor;
  logic        root_start, root_done;
  logic [67:0] root_operand;
  logic [33:0] root_val;

  logic [7:0]  rdiv;
  logic [5:0]  rsh;
  logic [31:0] rq;

  logic signed [35:0] d36, ws;
  logic        cos_low, cos_high;
  logic [35:0] dw;
  logic signed [34:0] d_new;
  logic signed [33:0] pdx, pdy, pdz;
  logic [32:0] t_cos;
  logic [17:0] st_cos;
  logic [30:0] t_tanh;
  logic [17:0] st_tanh;
  logic signed [49:0] sum;
  logic [49:0] rnd;

  assign busy   = state != S_IDLE;
  assign pready = 1'b1;
  assign w      = (interface_width == '0) ? 31'd1 : interface_width;
  assign three  = dimension == 2'd3;
  assign sharp  = profile_mode[1];

  always_comb begin
    if (circle_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (32'(circle_count) > 32'(MAX_CIRCLES)) begin
      count_eff = CNT_W'(MAX_CIRCLES);
    end else begin
      count_eff = CNT_W'(circle_count);
    end
  end

  assign last = CNT_W'(circ_idx + CNT_W'(1)) == count_eff;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_count      <= 5'd1;
      dimension         <= 2'd2;
      profile_mode      <= 2'd0;
      interface_width   <= 31'd65536;
      background_enable <= 1'b0;
      background_level  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        mcsf_pkg::REG_COUNT:    circle_count      <= pwdata[4:0];
        mcsf_pkg::REG_DIM:      dimension         <= pwdata[1:0];
        mcsf_pkg::REG_PROFILE:  profile_mode      <= pwdata[1:0];
        mcsf_pkg::REG_WIDTH:    interface_width   <= pwdata[30:0];
        mcsf_pkg::REG_BG_EN:    background_enable <= pwdata[0];
        mcsf_pkg::REG_BG_LEVEL: background_level  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mcsf_pkg::REG_COUNT:    prdata = {27'b0, circle_count};
      mcsf_pkg::REG_DIM:      prdata = {30'b0, dimension};
      mcsf_pkg::REG_PROFILE:  prdata = {30'b0, profile_mode};
      mcsf_pkg::REG_WIDTH:    prdata = {1'b0, interface_width};
      mcsf_pkg::REG_BG_EN:    prdata = {31'b0, background_enable};
      mcsf_pkg::REG_BG_LEVEL: prdata = background_level;
      default:                prdata = '0;
    endcase
  end

  // circle table
  always_ff @(posedge clk) begin
    if (start && !busy && operation == mcsf_pkg::OP_LOAD &&
        32'(circle_slot) < 32'(MAX_CIRCLES)) begin
      mem[IDX_W'(circle_slot)] <= '{cx: coord_x, cy: coord_y, cz: coord_z,
                                    radius: circle_radius, vin: value_inside,
                                    vout: value_outside};
    end
    rd <= mem[circ_idx[IDX_W-1:0]];
  end

  // series divisor for the current step, divided by reciprocal multiplication
  assign rdiv = (state == S_CPD || state == S_CPW) ? 8'(mcsf_pkg::cos_div(k)) : {4'b0, k};
  assign rsh  = mcsf_pkg::recip_shift(rdiv);
  assign rq   = 32'(mul_q >> rsh);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin mul_a = {1'b0, dx}; mul_b = {1'b0, dx}; end
      S_SQY: begin mul_a = {1'b0, dy}; mul_b = {1'b0, dy}; end
      S_SQZ: begin mul_a = {1'b0, dz}; mul_b = {1'b0, dz}; end
      S_CA: begin mul_a = 34'(h); mul_b = 34'(mcsf_pkg::PI_Q30); end
      S_CX2: begin mul_a = 34'(mul_q[46:16]); mul_b = 34'(mul_q[46:16]); end
      S_CPM, S_CFIN: begin mul_a = 34'(x2); mul_b = 34'(p); end
      S_CPD: begin
        mul_a = 34'(mul_q[61:30]);
        mul_b = 34'(mcsf_pkg::recip_mul(rdiv));
      end
      S_TPM: begin mul_a = 34'(f30); mul_b = 34'(p); end
      S_TPD: begin
        mul_a = 34'(mul_q[59:30]);
        mul_b = 34'(mcsf_pkg::recip_mul(rdiv));
      end
      S_TE: begin mul_a = 34'(p); mul_b = 34'(mcsf_pkg::EINV_Q30); end
      S_VAL1: begin
        mul_a = {{2{rd.vin[31]}}, rd.vin};
        mul_b = 34'(17'(mcsf_pkg::S_ONE - s));
      end
      S_VAL2: begin mul_a = {{2{rd.vout[31]}}, rd.vout}; mul_b = 34'(s); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // profile helpers
  assign d36      = 36'(d);
  assign ws       = $signed({5'b0, w});
  assign cos_low  = d36 <= -ws;
  assign cos_high = d36 >= ws;
  assign dw       = 36'(d36 + ws);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_PROF: begin
        if (profile_mode == mcsf_pkg::PROF_TANH) begin
          div_start    = 1'b1;
          div_dividend = {12'b0, mag, 17'b0};
          div_divisor  = {1'b0, w};
        end else if (!sharp && !cos_low && !cos_high) begin
          div_start    = 1'b1;
          div_dividend = {16'b0, dw[31:0], 16'b0};
          div_divisor  = {w, 1'b0};
        end
      end
      S_TE: begin
        if (n == '0) begin
          div_start    = 1'b1;
          div_dividend = 64'h1000_0000_0000_0000;
          div_divisor  = 32'(mcsf_pkg::ONE30) + 32'(p);
        end
      end
      default: ;
    endcase
  end

  assign root_start   = state == S_SUM;
  assign root_operand = three ? 68'(acc + mul_q[67:0]) : acc;

  mcsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  mcsf_root u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (root_operand),
    .done    (root_done),
    .root    (root_val)
  );

  assign pdx   = 34'(px) - 34'($signed(rd.cx));
  assign pdy   = 34'(py) - 34'($signed(rd.cy));
  assign pdz   = 34'(pz) - 34'($signed(rd.cz));
  assign d_new = $signed({1'b0, root_val}) - $signed({4'b0, rd.radius});

  // cosine weight: (1 - cos)/2 with the sign of cos folded for the upper half
  assign t_cos   = (xi > 17'd32768) ? 33'(33'h0_8000_0000 - 33'(mul_q[61:31]))
                                    : 33'(mul_q[61:31]);
  assign st_cos  = 18'(33'(t_cos + 33'd16384) >> 15);
  assign t_tanh  = d[34] ? 31'(mcsf_pkg::ONE30 - s30) : s30;
  assign st_tanh = 18'(31'(t_tanh + 31'd8192) >> 14);

  assign sum = $signed(prod) + $signed(mul_q[49:0]);
  assign rnd = 50'(sum + 50'sd32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      circ_idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && operation == mcsf_pkg::OP_EVAL) begin
            circ_idx <= '0;
            state    <= S_READ;
          end
        end
        S_READ: state <= S_DIFF;
        S_DIFF: state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_SQZ;
        S_SQZ:  state <= S_SUM;
        S_SUM:  state <= S_ROOT;
        S_ROOT: if (root_done) state <= S_PROF;
        S_PROF: begin
          if (profile_mode == mcsf_pkg::PROF_TANH) begin
            state <= S_TDIVW;
          end else if (sharp || cos_low || cos_high) begin
            state <= S_VAL1;
          end else begin
            state <= S_CDIVW;
          end
        end
        S_CDIVW: if (div_done) state <= S_CA;
        S_CA:    state <= S_CX2;
        S_CX2:   state <= S_CX2W;
        S_CX2W:  state <= S_CPM;
        S_CPM:   state <= S_CPD;
        S_CPD:   state <= S_CPW;
        S_CPW: begin
          k     <= k + 4'd1;
          state <= (k == 4'd4) ? S_CFIN : S_CPM;
        end
        S_CFIN: state <= S_CC;
        S_CC:   state <= S_VAL1;
        S_TDIVW: begin
          if (div_done) begin
            state <= (div_quotient[63:20] != '0) ? S_TS : S_TPM;
            k     <= 4'd10;
          end
        end
        S_TPM: state <= S_TPD;
        S_TPD: state <= S_TPW;
        S_TPW: begin
          k     <= k - 4'd1;
          state <= (k == 4'd1) ? S_TE : S_TPM;
        end
        S_TE:   state <= (n == '0) ? S_TRW : S_TEW;
        S_TEW:  state <= S_TE;
        S_TRW:  if (div_done) state <= S_TS;
        S_TS:   state <= S_VAL1;
        S_VAL1: state <= S_VAL2;
        S_VAL2: state <= S_VAL3;
        S_VAL3: begin
          if (last) begin
            state <= S_OUT;
          end else begin
            circ_idx <= CNT_W'(circ_idx + CNT_W'(1));
            state    <= S_READ;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_CX2W) k <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px <= coord_x;
        py <= coord_y;
        pz <= coord_z;
      end
      S_DIFF: begin
        dx <= pdx[33] ? 33'(-pdx) : pdx[32:0];
        dy <= pdy[33] ? 33'(-pdy) : pdy[32:0];
        dz <= pdz[33] ? 33'(-pdz) : pdz[32:0];
      end
      S_SQY: acc <= mul_q[67:0];
      S_SQZ: acc <= 68'(acc + mul_q[67:0]);
      S_ROOT: begin
        d   <= d_new;
        mag <= d_new[34] ? 35'(-d_new) : d_new;
      end
      S_PROF: begin
        if (sharp) begin
          s <= d[34] ? 17'd0 : mcsf_pkg::S_ONE;
        end else if (cos_low) begin
          s <= 17'd0;
        end else begin
          s <= mcsf_pkg::S_ONE;
        end
      end
      S_CDIVW: begin
        xi <= div_quotient[16:0];
        h  <= (div_quotient[16:0] > 17'd32768) ? 16'(17'd65536 - div_quotient[16:0])
                                              : div_quotient[15:0];
      end
      S_CX2W: begin
        x2 <= mul_q[61:30];
        p  <= mcsf_pkg::ONE30;
      end
      S_CPW: p <= 31'(mcsf_pkg::ONE30 - rq[30:0]);
      S_CC: s <= (st_cos > 18'd65536) ? mcsf_pkg::S_ONE : st_cos[16:0];
      S_TDIVW: begin
        s30 <= mcsf_pkg::ONE30;
        n   <= div_quotient[19:16];
        f30 <= {div_quotient[15:0], 14'b0};
        p   <= mcsf_pkg::ONE30;
      end
      S_TPW: p <= 31'(mcsf_pkg::ONE30 - rq[30:0]);
      S_TEW: begin
        p <= 31'(mul_q[59:30]);
        n <= n - 4'd1;
      end
      S_TRW: if (div_done) s30 <= div_quotient[30:0];
      S_TS: s <= (st_tanh > 18'd65536) ? mcsf_pkg::S_ONE : st_tanh[16:0];
      S_VAL2: prod <= mul_q[49:0];
      S_VAL3: begin
        if (circ_idx == '0 || mag < best_abs) begin
          best_abs <= mag;
          best_val <= rnd[47:16];
        end
      end
      S_OUT: begin
        if (background_enable && (sharp ? (best_abs != '0) : (best_abs > {4'b0, w}))) begin
          field_value <= background_level;
        end else begin
          field_value <= best_val;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for multi_circle_smooth_field: loads circle entries, evaluates points
// and compares each field_value with a fixed-point predictor kept in this file
// depends on mcsf_pkg and the multi_circle_smooth_field rtl

module testbench;

  localparam longint unsigned Q30 = 64'd1073741824;
  localparam longint unsigned LIMIT_CYCLES = 64'd60_000_000;

  // queue of expected field values, in evaluation order
  class field_scoreboard;
    logic [31:0] pending[$];
    int errors;

    function void note_eval(logic [31:0] v);
      pending.push_back(v);
    endfunction

    task flag(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        flag($sformatf("field_value %h with no evaluation pending", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) flag($sformatf("field_value %h, predicted %h", got, want));
      end
    endtask
  endclass

  logic clk, rst, start, busy, operation, done, psel, penable, pwrite, pready;
  logic [3:0] circle_slot;
  logic signed [31:0] coord_x, coord_y, coord_z, value_inside, value_outside, field_value;
  logic [30:0] circle_radius;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  multi_circle_smooth_field i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .circle_slot(circle_slot), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .circle_radius(circle_radius), .value_inside(value_inside),
    .value_outside(value_outside), .done(done), .field_value(field_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  field_scoreboard sb;

  // predictor copy of the circle table and registers
  logic [31:0] tbl_x[16], tbl_y[16], tbl_z[16], tbl_in[16], tbl_out[16];
  logic [30:0] tbl_r[16];
  logic [4:0] cfg_count;
  logic [1:0] cfg_dim, cfg_profile;
  logic [30:0] cfg_width;
  logic cfg_bg_en;
  logic [31:0] cfg_bg_level;
  int idle_pct;
  longint unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst && done) sb.check(field_value);
  end

  function automatic longint unsigned root_floor(logic [67:0] v);
    longint unsigned rem, root, trial;
    rem = 0;
    root = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 64'((v >> (2 * i)) & 68'd3);
      root = root << 1;
      trial = (root << 1) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root |= 64'd1;
      end
    end
    return root;
  endfunction

  function automatic longint clamp_weight(longint s);
    if (s < 0) return 0;
    if (s > 65536) return 65536;
    return s;
  endfunction

  // (1 - cos(pi*xi))/2 with xi in Q16.16
  function automatic longint cosine_ramp(longint unsigned xi);
    longint unsigned divs[5] = '{132, 90, 56, 30, 12};
    longint unsigned h, a, x2, p;
    longint c;
    h = xi > 32768 ? 65536 - xi : xi;
    a = (h * 64'(mcsf_pkg::PI_Q30)) >> 16;
    x2 = (a * a) >> 30;
    p = Q30;
    for (int i = 0; i < 5; i++) p = Q30 - ((x2 * p) >> 30) / divs[i];
    c = longint'(Q30) - longint'(((x2 * p) >> 30) / 2);
    if (xi > 32768) c = -c;
    return clamp_weight((longint'(Q30) - c + 16384) / 32768);
  endfunction

  function automatic longint tanh_ramp(longint d, longint unsigned w);
    longint unsigned mag, u, s30, n, f30, p, e;
    mag = d < 0 ? longint'(-d) : d;
    u = (mag << 17) / w;
    if (u >= (64'd16 << 16)) begin
      s30 = Q30;
    end else begin
      n = u >> 16;
      f30 = (u & 64'hFFFF) << 14;
      p = Q30;
      for (int k = 10; k >= 1; k--) p = Q30 - ((f30 * p) >> 30) / longint'(k);
      e = p;
      while (n > 0) begin
        e = (e * 64'(mcsf_pkg::EINV_Q30)) >> 30;
        n--;
      end
      s30 = (Q30 << 30) / (Q30 + e);
    end
    if (d < 0) s30 = Q30 - s30;
    return clamp_weight(longint'((s30 + 8192) >> 14));
  endfunction

  function automatic logic [31:0] predict_field(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz);
    longint unsigned w, mag, best_abs, q;
    longint d, s, sum, best_val, a, b;
    logic [67:0] acc;
    int count;
    logic sharp;
    count = cfg_count == 0 ? 1 : (cfg_count > 16 ? 16 : int'(cfg_count));
    w = cfg_width == 0 ? 1 : 64'(cfg_width);
    sharp = cfg_profile >= 2;
    best_abs = 0;
    best_val = 0;
    for (int i = 0; i < count; i++) begin
      a = longint'(signed'(px));
      b = longint'(signed'(tbl_x[i]));
      q = a >= b ? a - b : b - a;
      acc = 68'(q * q);
      a = longint'(signed'(py));
      b = longint'(signed'(tbl_y[i]));
      q = a >= b ? a - b : b - a;
      acc += 68'(q * q);
      if (cfg_dim == 3) begin
        a = longint'(signed'(pz));
        b = longint'(signed'(tbl_z[i]));
        q = a >= b ? a - b : b - a;
        acc += 68'(q * q);
      end
      d = longint'(root_floor(acc)) - longint'(tbl_r[i]);
      if (sharp) s = d >= 0 ? 65536 : 0;
      else if (cfg_profile == mcsf_pkg::PROF_TANH) s = tanh_ramp(d, w);
      else if (d <= -longint'(w)) s = 0;
      else if (d >= longint'(w)) s = 65536;
      else s = cosine_ramp(longint'(unsigned'((d + longint'(w)) * 65536)) / (2 * w));
      sum = longint'(signed'(tbl_in[i])) * (65536 - s) + longint'(signed'(tbl_out[i])) * s;
      mag = d < 0 ? longint'(-d) : d;
      if (i == 0 || mag < best_abs) begin
        best_abs = mag;
        best_val = (sum + 32768) >>> 16;
      end
    end
    if (cfg_bg_en && (sharp ? best_abs > 0 : best_abs > w)) return cfg_bg_level;
    return best_val[31:0];
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mcsf_pkg::REG_COUNT:    cfg_count = value[4:0];
      mcsf_pkg::REG_DIM:      cfg_dim = value[1:0];
      mcsf_pkg::REG_PROFILE:  cfg_profile = value[1:0];
      mcsf_pkg::REG_WIDTH:    cfg_width = value[30:0];
      mcsf_pkg::REG_BG_EN:    cfg_bg_en = value[0];
      mcsf_pkg::REG_BG_LEVEL: cfg_bg_level = value;
      default: ;
    endcase
  endtask

  // block must be idle: all results in, and any trailing load finished
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [3:0] slot, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [30:0] r, logic [31:0] vi,
                           logic [31:0] vo);
    logic took;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    circle_slot <= slot;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    circle_radius <= r;
    value_inside <= vi;
    value_outside <= vo;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    if (op == mcsf_pkg::OP_EVAL) begin
      sb.note_eval(predict_field(x, y, z));
    end else begin
      tbl_x[slot] = x;
      tbl_y[slot] = y;
      tbl_z[slot] = z;
      tbl_r[slot] = r;
      tbl_in[slot] = vi;
      tbl_out[slot] = vo;
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return $urandom_range(1) ? 32'h0010_0000 : 32'hfff0_0000;
      default: return 32'($urandom_range(0, 20 << 16)) - 32'(10 << 16);
    endcase
  endfunction

  function automatic logic [30:0] pick_radius();
    case ($urandom_range(7))
      0: return 31'($urandom);
      1: return $urandom_range(1) ? 31'd1 : 31'h7fff_ffff;
      default: return 31'($urandom_range(1, 8 << 16));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($urandom_range(0, 200 << 16)) - 32'(100 << 16);
    endcase
  endfunction

  task automatic random_load();
    send_item(mcsf_pkg::OP_LOAD, 4'($urandom_range(15)), pick_coord(), pick_coord(),
              pick_coord(), pick_radius(), pick_value(), pick_value());
  endtask

  task automatic random_eval();
    send_item(mcsf_pkg::OP_EVAL, 4'($urandom), pick_coord(), pick_coord(), pick_coord(),
              31'($urandom), $urandom, $urandom);
  endtask

  task automatic configure(logic [4:0] cnt, logic [1:0] dim, logic [1:0] prof,
                           logic [30:0] w, logic bg_en, logic [31:0] bg);
    drain();
    reg_write(mcsf_pkg::REG_COUNT, 32'(cnt));
    reg_write(mcsf_pkg::REG_DIM, 32'(dim));
    reg_write(mcsf_pkg::REG_PROFILE, 32'(prof));
    reg_write(mcsf_pkg::REG_WIDTH, 32'(w));
    reg_write(mcsf_pkg::REG_BG_EN, 32'(bg_en));
    reg_write(mcsf_pkg::REG_BG_LEVEL, bg);
  endtask

  // per-phase settings; counts of 16 and 31 go with sharp profiles, 17 with cosine
  logic [4:0] ph_count[12] = '{1, 2, 0, 3, 16, 4, 1, 31, 2, 5, 17, 3};
  logic [1:0] ph_dim[12] = '{2, 3, 0, 3, 1, 2, 3, 3, 2, 3, 2, 3};
  logic [1:0] ph_prof[12] = '{0, 1, 2, 0, 2, 1, 3, 3, 1, 0, 0, 1};

  initial begin
    logic [30:0] w;
    sb = new();
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    operation = mcsf_pkg::OP_LOAD;
    circle_slot = '0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    circle_radius = '0;
    value_inside = '0;
    value_outside = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 7;
    cfg_count = 1;
    cfg_dim = 2;
    cfg_profile = mcsf_pkg::PROF_COS;
    cfg_width = 31'd65536;
    cfg_bg_en = 1'b0;
    cfg_bg_level = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: fill the table with extremes, then evaluate at and around them
    for (int i = 0; i < 16; i++) begin
      send_item(mcsf_pkg::OP_LOAD, 4'(i), i[0] ? 32'h7fff_ffff : 32'h8000_0000,
                i[1] ? 32'h7fff_ffff : 32'h8000_0000, i[2] ? 32'h7fff_ffff : 32'h0,
                i[3] ? 31'h7fff_ffff : 31'd1, i[0] ? 32'h8000_0000 : 32'h7fff_ffff,
                i[0] ? 32'h7fff_ffff : 32'h8000_0000);
    end
    send_item(mcsf_pkg::OP_LOAD, 4'd0, 32'h0, 32'h0, 32'h0, 31'h0002_0000, 32'h0001_0000,
              32'h0);
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h0, 32'h0, 32'h0, 31'd0, 32'd0, 32'd0); // center
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h0002_0000, 32'h0, 32'h0, 31'd0, 32'd0,
              32'd0); // on rim
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd0,
              32'd0, 32'd0);
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,
              32'd0, 32'd0);
    configure(5'd16, 2'd3, 2'd1, 31'd0, 1'b1, 32'h8000_0000);
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'd0,
              32'd0, 32'd0);
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h0, 32'h0, 32'h0, 31'd0, 32'd0, 32'd0);
    configure(5'd1, 2'd2, 2'd0, 31'h7fff_ffff, 1'b1, 32'h7fff_ffff);
    send_item(mcsf_pkg::OP_EVAL, 4'd0, 32'h0001_0000, 32'h0, 32'h0, 31'd0, 32'd0, 32'd0);

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = ph < 4 ? 7 : (ph < 8 ? 67 : 0);
      case (ph % 4)
        0: w = 31'd1;
        1: w = 31'($urandom_range(1 << 12, 4 << 16));
        2: w = ph == 6 ? 31'd0 : 31'h7fff_ffff;
        default: w = 31'($urandom);
      endcase
      configure(ph_count[ph], ph_dim[ph], ph_prof[ph], w, 1'($urandom), $urandom);
      // make sure every slot is loaded before this setting reads it
      for (int i = 0; i < 16; i++) begin
        send_item(mcsf_pkg::OP_LOAD, 4'(i), pick_coord(), pick_coord(), pick_coord(),
                  pick_radius(), pick_value(), pick_value());
      end
      for (int n = 0; n < (ph_count[ph] >= 16 ? 25 : 62); n++) begin
        if (n == 20) drain(); // hold the sender until every result is in
        if ($urandom_range(99) < 30) random_load();
        else random_eval();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.pending.size() != 0) sb.flag("evaluations left without a result");
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- multi_circle_smooth_field.f -----
rtl/core/mcsf_pkg.sv
rtl/core/mcsf_div.sv
rtl/core/mcsf_root.sv
rtl/core/multi_circle_smooth_field.sv
tb/testbench.sv
